// ===== rtl/core/ete_pkg.sv =====
package ete_pkg;

    // Receive buffer size in bytes; bytes past this count are ignored.
    localparam int BUFFER_BYTES = 4096;
    localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);

    localparam int MAX_RESULTS  = 3;

    localparam logic [1:0] KIND_TEXT    = 2'd0;
    localparam logic [1:0] KIND_LINE    = 2'd1;
    localparam logic [1:0] KIND_RECEIPT = 2'd2;

    typedef struct packed {
        logic [7:0] char_code;
        logic [7:0] spaces_before;
        logic [1:0] result_kind;
    } ete_result_t;

    typedef struct packed {
        logic [1:0]                        count;
        ete_result_t [MAX_RESULTS-1:0]     item;
    } ete_bundle_t;

endpackage

// ===== rtl/core/ete_parser.sv =====
module ete_parser
    import ete_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic [7:0]  data_byte,
    input  logic        end_of_receipt,
    output ete_bundle_t bundle
);

    localparam logic [3:0] M_IDLE      = 4'd0;
    localparam logic [3:0] M_ESC_CMD   = 4'd1;
    localparam logic [3:0] M_GS_CMD    = 4'd2;
    localparam logic [3:0] M_GSK_TYPE  = 4'd3;
    localparam logic [3:0] M_GSK_COUNT = 4'd4;
    localparam logic [3:0] M_GSK_NUL   = 4'd5;
    localparam logic [3:0] M_GSP_FN    = 4'd6;
    localparam logic [3:0] M_GSP_LO    = 4'd7;
    localparam logic [3:0] M_GSP_HI    = 4'd8;
    localparam logic [3:0] M_SKIP      = 4'd9;

    localparam logic [7:0] B_ESC = 8'h1B;
    localparam logic [7:0] B_GS  = 8'h1D;
    localparam logic [7:0] B_FS  = 8'h1C;
    localparam logic [7:0] B_DLE = 8'h10;
    localparam logic [7:0] B_LF  = 8'h0A;
    localparam logic [7:0] B_CR  = 8'h0D;
    localparam logic [7:0] B_HT  = 8'h09;
    localparam logic [7:0] B_SP  = 8'h20;
    localparam logic [7:0] TOP_PRINTABLE = 8'h7E;
    localparam logic [7:0] EXT_BASE      = 8'h80;
    localparam logic [7:0] GSK_MIN_COUNTED = 8'd65;

    logic [3:0]       mode_reg,    mode_next;
    logic [15:0]      skip_reg,    skip_next;
    logic [7:0]       lo_reg,      lo_next;
    logic             lht_reg,     lht_next;
    logic [7:0]       pend_reg,    pend_next;
    logic [CNT_W-1:0] cnt_reg,     cnt_next;

    logic             proc_emit;
    ete_result_t      proc_res;
    logic [8:0]       pend_sum;
    logic [7:0]       space_add;
    logic             do_space;
    logic             do_skip;
    logic [15:0]      skip_len;
    logic [1:0]       n;

    always_comb begin
        mode_next = mode_reg;
        skip_next = skip_reg;
        lo_next   = lo_reg;
        lht_next  = lht_reg;
        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        proc_emit = 1'b0;
        proc_res  = '0;
        do_space  = 1'b0;
        space_add = 8'd0;
        do_skip   = 1'b0;
        skip_len  = 16'd0;

        if (cnt_reg < CNT_W'(BUFFER_BYTES)) begin
            cnt_next = cnt_reg + CNT_W'(1);
            unique case (mode_reg)
                M_IDLE: begin
                    if (data_byte == B_ESC) begin
                        mode_next = M_ESC_CMD;
                    end else if (data_byte == B_GS) begin
                        mode_next = M_GS_CMD;
                    end else if (data_byte == B_FS) begin
                        do_skip  = 1'b1;
                        skip_len = 16'd2;
                    end else if (data_byte == B_DLE) begin
                        do_skip  = 1'b1;
                        skip_len = 16'd3;
                    end else if (data_byte == B_LF || data_byte == B_CR) begin
                        if (lht_reg) begin
                            proc_emit = 1'b1;
                            proc_res.result_kind = KIND_LINE;
                        end
                        lht_next  = 1'b0;
                        pend_next = 8'd0;
                    end else if (data_byte == B_HT) begin
                        do_space  = 1'b1;
                        space_add = 8'd4;
                    end else if (data_byte == B_SP) begin
                        do_space  = 1'b1;
                        space_add = 8'd1;
                    end else if ((data_byte > B_SP && data_byte <= TOP_PRINTABLE) ||
                                 data_byte >= EXT_BASE) begin
                        proc_emit = 1'b1;
                        proc_res.result_kind   = KIND_TEXT;
                        proc_res.spaces_before = pend_reg;
                        proc_res.char_code     = data_byte;
                        pend_next = 8'd0;
                        lht_next  = 1'b1;
                    end
                end
                M_ESC_CMD: begin
                    if (data_byte == "E" || data_byte == "a" || data_byte == "!" ||
                        data_byte == "d" || data_byte == "J" || data_byte == "M" ||
                        data_byte == "R" || data_byte == "t") begin
                        do_skip  = 1'b1;
                        skip_len = 16'd1;
                    end else if (data_byte == "p") begin
                        do_skip  = 1'b1;
                        skip_len = 16'd3;
                    end else begin
                        mode_next = M_IDLE;
                    end
                end
                M_GS_CMD: begin
                    if (data_byte == "k") begin
                        mode_next = M_GSK_TYPE;
                    end else if (data_byte == "(") begin
                        mode_next = M_GSP_FN;
                    end else begin
                        do_skip  = 1'b1;
                        skip_len = 16'd1;
                    end
                end
                M_GSK_TYPE: begin
                    mode_next = (data_byte >= GSK_MIN_COUNTED) ? M_GSK_COUNT : M_GSK_NUL;
                end
                M_GSK_COUNT: begin
                    do_skip  = 1'b1;
                    skip_len = {8'd0, data_byte};
                end
                M_GSK_NUL: begin
                    if (data_byte == 8'd0) begin
                        mode_next = M_IDLE;
                    end
                end
                M_GSP_FN: begin
                    mode_next = M_GSP_LO;
                end
                M_GSP_LO: begin
                    lo_next   = data_byte;
                    mode_next = M_GSP_HI;
                end
                M_GSP_HI: begin
                    do_skip  = 1'b1;
                    skip_len = {data_byte, lo_reg};
                end
                M_SKIP: begin
                    skip_next = (skip_reg != 16'd0) ? skip_reg - 16'd1 : skip_reg;
                    if (skip_next == 16'd0) begin
                        mode_next = M_IDLE;
                    end
                end
                default: begin
                    mode_next = M_IDLE;
                end
            endcase
        end

        // Spaces count only after text on this line; saturate at 255.
        pend_sum = {1'b0, pend_reg} + {1'b0, space_add};
        if (do_space && lht_reg) begin
            pend_next = pend_sum[8] ? 8'hFF : pend_sum[7:0];
        end

        if (do_skip) begin
            skip_next = skip_len;
            mode_next = (skip_len != 16'd0) ? M_SKIP : M_IDLE;
        end

        // Collect results in order: processed byte, closing line end, receipt end.
        bundle = '0;
        n      = 2'd0;
        if (proc_emit) begin
            bundle.item[n] = proc_res;
            n = n + 2'd1;
        end
        if (end_of_receipt) begin
            if (lht_next) begin
                bundle.item[n].result_kind = KIND_LINE;
                n = n + 2'd1;
            end
            bundle.item[n].result_kind = KIND_RECEIPT;
            n = n + 2'd1;
            mode_next = M_IDLE;
            skip_next = 16'd0;
            lo_next   = 8'd0;
            lht_next  = 1'b0;
            pend_next = 8'd0;
            cnt_next  = '0;
        end
        bundle.count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            skip_reg <= 16'd0;
            lo_reg   <= 8'd0;
            lht_reg  <= 1'b0;
            pend_reg <= 8'd0;
            cnt_reg  <= '0;
        end else if (advance) begin
            mode_reg <= mode_next;
            skip_reg <= skip_next;
            lo_reg   <= lo_next;
            lht_reg  <= lht_next;
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/ete_serializer.sv =====
module ete_serializer
    import ete_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        bnd_we,
    input  ete_bundle_t bnd_in,
    output logic        bnd_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tlast
);

    logic        bnd_vld_reg;
    ete_bundle_t bnd_reg;
    logic [1:0]  idx_reg;
    logic        out_vld_reg;
    ete_result_t out_reg;
    logic        out_last_reg;

    logic        out_load;
    logic        bnd_take;
    logic        idx_last;
    logic        bnd_done;

    assign out_load  = !out_vld_reg || m_tready;
    assign bnd_take  = bnd_vld_reg && out_load;
    assign idx_last  = (idx_reg == 2'(bnd_reg.count - 2'd1));
    assign bnd_done  = bnd_take && idx_last;
    assign bnd_ready = !bnd_vld_reg || bnd_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bnd_vld_reg <= 1'b0;
            idx_reg     <= 2'd0;
            out_vld_reg <= 1'b0;
        end else begin
            if (bnd_we && bnd_in.count != 2'd0) begin
                bnd_vld_reg <= 1'b1;
                idx_reg     <= 2'd0;
            end else if (bnd_done) begin
                bnd_vld_reg <= 1'b0;
            end else if (bnd_take) begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (out_load) begin
                out_vld_reg <= bnd_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (bnd_we) begin
            bnd_reg <= bnd_in;
        end
        if (bnd_take) begin
            out_reg      <= bnd_reg.item[idx_reg];
            out_last_reg <= idx_last;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/core/escpos_text_extractor_top.sv =====
// Path: the first result of a byte reaches m_tdata through the input register,
//   then the bundle register, then the output register.
// Throughput: one byte per cycle while m_tready is high and no byte yields more than
//   one result; a byte with more (up to 3) holds the input until its last is loaded.
// Reset: aresetn is synchronous, active low; it returns the parser to text mode,
//   clears counters and line state, and empties all stages.
module escpos_text_extractor_top
    import ete_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_receipt
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [1:0] result_kind, [9:2] spaces_before,
                                   // [17:10] char_code, [23:18] zero
    output logic        m_tlast    // last_of_run
);

    // Input register: holds one byte until the bundle stage can take it.
    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eor_reg;

    logic        bnd_ready;
    logic        advance;
    ete_bundle_t bundle;

    // Advance the parser when the bundle stage frees up this cycle.
    assign advance  = in_vld_reg && bnd_ready;
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eor_reg  <= s_tlast;
        end
    end

    // Command decode, space and line tracking; yields up to three results per byte.
    ete_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .data_byte      (in_byte_reg),
        .end_of_receipt (in_eor_reg),
        .bundle         (bundle)
    );

    // Hold the result bundle and send its items one per cycle, while m_tready is high,
    // through the output register; last_of_run marks the final one.
    ete_serializer u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .bnd_we    (advance),
        .bnd_in    (bundle),
        .bnd_ready (bnd_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== bench/escpos_checker.sv =====
`timescale 1ns / 100ps

package escpos_tb_pkg;

    // Control bytes of the printer stream
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_DLE   = 8'h10;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_FS    = 8'h1C;
    localparam logic [7:0] CH_GS    = 8'h1D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam logic [7:0] CH_FIRST_PRINTABLE = 8'h21;
    localparam logic [7:0] CH_TOP_PRINTABLE   = 8'h7E;
    localparam logic [7:0] CH_EXT_BASE        = 8'h80;

    // ESC sub-commands
    localparam logic [7:0] ESC_INIT       = "@";
    localparam logic [7:0] ESC_BOLD       = "E";
    localparam logic [7:0] ESC_ALIGN      = "a";
    localparam logic [7:0] ESC_PRINT_MODE = "!";
    localparam logic [7:0] ESC_FEED_LINES = "d";
    localparam logic [7:0] ESC_FEED_DOTS  = "J";
    localparam logic [7:0] ESC_FONT       = "M";
    localparam logic [7:0] ESC_CHARSET    = "R";
    localparam logic [7:0] ESC_CODE_TABLE = "t";
    localparam logic [7:0] ESC_PULSE      = "p";

    // GS sub-commands
    localparam logic [7:0] GS_BARCODE = "k";
    localparam logic [7:0] GS_BLOCK   = "(";

    // Barcode types at or above this carry a byte count, below it end on NUL
    localparam logic [7:0] GSK_COUNTED_MIN = 8'd65;

    localparam int SPACES_PER_TAB = 4;
    localparam int SPACES_MAX     = 255;

endpackage

module escpos_checker
    import ete_pkg::*;
    import escpos_tb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          results_owed
);

    typedef enum logic [3:0] {
        PM_TEXT, PM_ESC, PM_GS, PM_GSK_TYPE, PM_GSK_COUNT, PM_GSK_NUL,
        PM_GSP_FN, PM_GSP_LO, PM_GSP_HI, PM_SKIP
    } parse_mode_e;

    typedef struct packed {
        ete_result_t res;
        logic        last;
    } expected_t;

    parse_mode_e      mode;
    logic [15:0]      skip_left;
    logic [7:0]       len_low;
    logic             line_open;
    logic [7:0]       held_spaces;
    logic [CNT_W-1:0] byte_count;

    expected_t   expected_q[$];
    ete_result_t byte_results[$];
    int          errors = 0;

    assign fail_count = errors;

    task automatic clear_state();
        mode        = PM_TEXT;
        skip_left   = '0;
        len_low     = '0;
        line_open   = 1'b0;
        held_spaces = '0;
        byte_count  = '0;
    endtask

    task automatic emit(input logic [1:0] kind, input logic [7:0] sp, input logic [7:0] ch);
        ete_result_t r;
        r.result_kind   = kind;
        r.spaces_before = sp;
        r.char_code     = ch;
        byte_results.insert(byte_results.size(), r);
    endtask

    task automatic hold_spaces(input int n);
        int sum;
        sum = held_spaces + n;
        if (line_open)
            held_spaces = (sum > SPACES_MAX) ? SPACES_MAX[7:0] : sum[7:0];
    endtask

    task automatic begin_skip(input logic [15:0] n);
        skip_left = n;
        mode      = (n != 0) ? PM_SKIP : PM_TEXT;
    endtask

    task automatic text_byte(input logic [7:0] b);
        if (b == CH_ESC) begin
            mode = PM_ESC;
        end else if (b == CH_GS) begin
            mode = PM_GS;
        end else if (b == CH_FS) begin
            begin_skip(16'd2);
        end else if (b == CH_DLE) begin
            begin_skip(16'd3);
        end else if (b == CH_LF || b == CH_CR) begin
            if (line_open)
                emit(KIND_LINE, 8'd0, 8'd0);
            line_open   = 1'b0;
            held_spaces = '0;
        end else if (b == CH_HT) begin
            hold_spaces(SPACES_PER_TAB);
        end else if (b == CH_SPACE) begin
            hold_spaces(1);
        end else if ((b >= CH_FIRST_PRINTABLE && b <= CH_TOP_PRINTABLE) ||
                     b >= CH_EXT_BASE) begin
            emit(KIND_TEXT, held_spaces, b);
            held_spaces = '0;
            line_open   = 1'b1;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        case (mode)
            PM_TEXT: text_byte(b);
            PM_ESC: begin
                case (b)
                    ESC_BOLD, ESC_ALIGN, ESC_PRINT_MODE, ESC_FEED_LINES,
                    ESC_FEED_DOTS, ESC_FONT, ESC_CHARSET, ESC_CODE_TABLE:
                        begin_skip(16'd1);
                    ESC_PULSE: begin_skip(16'd3);
                    default: mode = PM_TEXT;
                endcase
            end
            PM_GS: begin
                if (b == GS_BARCODE)
                    mode = PM_GSK_TYPE;
                else if (b == GS_BLOCK)
                    mode = PM_GSP_FN;
                else
                    begin_skip(16'd1);
            end
            PM_GSK_TYPE:  mode = (b >= GSK_COUNTED_MIN) ? PM_GSK_COUNT : PM_GSK_NUL;
            PM_GSK_COUNT: begin_skip({8'd0, b});
            PM_GSK_NUL: begin
                if (b == CH_NUL)
                    mode = PM_TEXT;
            end
            PM_GSP_FN: mode = PM_GSP_LO;
            PM_GSP_LO: begin
                len_low = b;
                mode    = PM_GSP_HI;
            end
            PM_GSP_HI: begin_skip({b, len_low});
            PM_SKIP: begin
                if (skip_left != 0)
                    skip_left = skip_left - 16'd1;
                if (skip_left == 0)
                    mode = PM_TEXT;
            end
            default: mode = PM_TEXT;
        endcase
    endtask

    // Work out every result one accepted byte causes and queue them in order.
    task automatic predict_byte(input logic [7:0] b, input logic eor);
        expected_t e;
        byte_results.delete();
        if (byte_count < BUFFER_BYTES) begin
            byte_count = byte_count + 1'b1;
            parse_byte(b);
        end
        if (eor) begin
            if (line_open)
                emit(KIND_LINE, 8'd0, 8'd0);
            emit(KIND_RECEIPT, 8'd0, 8'd0);
            clear_state();
        end
        foreach (byte_results[i]) begin
            e.res  = byte_results[i];
            e.last = (i == byte_results.size() - 1);
            expected_q.insert(expected_q.size(), e);
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    task automatic check_result();
        expected_t want;
        if (expected_q.size() == 0) begin
            errors++;
            $error("result with none pending: tdata %h tlast %b", m_tdata, m_tlast);
        end else begin
            want = expected_q.pop_front();
            compare_field("result_kind",   int'(want.res.result_kind),   int'(m_tdata[1:0]));
            compare_field("spaces_before", int'(want.res.spaces_before), int'(m_tdata[9:2]));
            compare_field("char_code",     int'(want.res.char_code),     int'(m_tdata[17:10]));
            compare_field("last_of_run",   int'(want.last),              int'(m_tlast));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
            expected_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_result();
        end
        results_owed <= expected_q.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import escpos_tb_pkg::*;

    // Generous bound: a few thousand items, even at worst-case stalling, stay far below it.
    localparam int LIMIT_CYCLES     = 300_000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int RANDOM_PER_PHASE = 40;
    localparam int PHASES           = 4;
    // Receipt long enough to run past the 4096-byte buffer
    localparam int BLOCK_LEN        = 4080;
    localparam int OVERFLOW_TEXT    = 10;
    localparam int IGNORED_BYTES    = 5;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int items_sent   = 0;
    int cycle_count  = 0;
    int fail_count;
    int results_owed;

    // Idle percentages per phase: none, sender only, receiver only, both
    int phase_tx_pct[PHASES] = '{0, 71, 0, 24};
    int phase_rx_pct[PHASES] = '{0, 0, 71, 24};

    always #1 aclk = ~aclk;

    escpos_text_extractor_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    escpos_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    // Stall the result side at random, per cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Offer one item and hold it until the block takes it; idle first at random.
    task automatic send_item(input logic [7:0] b, input logic eor);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eor;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(b, 1'b0);
    endtask

    task automatic send_random_bytes(input int n);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(255)));
    endtask

    function automatic logic [7:0] random_text_char();
        if ($urandom_range(1))
            return 8'($urandom_range(CH_FIRST_PRINTABLE, CH_TOP_PRINTABLE));
        return 8'($urandom_range(CH_EXT_BASE, 255));
    endfunction

    function automatic logic [7:0] esc_one_arg();
        case ($urandom_range(7))
            0: return ESC_BOLD;
            1: return ESC_ALIGN;
            2: return ESC_PRINT_MODE;
            3: return ESC_FEED_LINES;
            4: return ESC_FEED_DOTS;
            5: return ESC_FONT;
            6: return ESC_CHARSET;
            default: return ESC_CODE_TABLE;
        endcase
    endfunction

    // Extremes of the byte ranges, spacing rules and a three-result receipt end.
    task automatic run_directed();
        send_byte(CH_SPACE);            // drop: leading space
        send_byte(CH_HT);               // drop: leading tab
        send_byte("A");                 // text, no spaces
        send_byte(CH_SPACE);
        send_byte(CH_HT);               // hold five spaces
        send_byte(8'hFF);               // top extended char with five spaces
        send_byte(CH_EXT_BASE);
        send_byte(CH_DEL);              // ignored
        send_byte(CH_NUL);              // ignored
        send_byte(CH_TOP_PRINTABLE);
        send_byte(CH_SPACE);            // trailing space, dropped by the line end
        send_byte(CH_CR);               // line end
        send_byte(CH_LF);               // empty line: nothing
        send_byte(CH_ESC);
        send_byte(ESC_INIT);            // no argument
        send_byte(CH_ESC);
        send_byte(ESC_PRINT_MODE);
        send_byte("Z");                 // argument, skipped
        send_byte(CH_GS);
        send_byte(GS_BLOCK);
        send_byte(8'h30);
        send_byte(8'h00);
        send_byte(8'h00);               // zero length: back to text at once
        send_byte("B");
        send_item("C", 1'b1);           // text, line end, receipt end
    endtask

    // Push the held space count past its ceiling.
    task automatic run_space_saturation();
        send_byte("A");
        repeat (64) send_byte(CH_HT);
        repeat (3) send_byte(CH_SPACE);
        send_byte("B");
        send_item(CH_CR, 1'b1);
    endtask

    // Fill the buffer exactly, then feed bytes that must be ignored.
    task automatic run_buffer_full();
        send_byte("X");
        send_byte(CH_GS);
        send_byte(GS_BLOCK);
        send_byte(8'h30);
        send_byte(BLOCK_LEN[7:0]);
        send_byte(BLOCK_LEN[15:8]);
        send_random_bytes(BLOCK_LEN);
        repeat (OVERFLOW_TEXT) send_byte(random_text_char());
        repeat (IGNORED_BYTES - 1) send_byte(random_text_char());
        send_item(random_text_char(), 1'b1);
    endtask

    // One random sequence: mostly well-formed text and commands, some noise.
    task automatic send_random_chunk();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 30) begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(random_text_char());
            repeat ($urandom_range(3)) send_byte($urandom_range(1) ? CH_SPACE : CH_HT);
        end else if (pick < 40) begin
            send_byte($urandom_range(1) ? CH_CR : CH_LF);
        end else if (pick < 50) begin
            send_byte(CH_ESC);
            n = $urandom_range(9);
            if (n < 5) begin
                send_byte(esc_one_arg());
                send_random_bytes(1);
            end else if (n < 7) begin
                send_byte(ESC_PULSE);
                send_random_bytes(3);
            end else begin
                send_random_bytes(1);
            end
        end else if (pick < 57) begin
            send_byte(CH_GS);
            send_byte(GS_BARCODE);
            send_byte(8'($urandom_range(GSK_COUNTED_MIN, 255)));
            n = $urandom_range(6);
            send_byte(8'(n));
            send_random_bytes(n);
        end else if (pick < 63) begin
            send_byte(CH_GS);
            send_byte(GS_BARCODE);
            send_byte(8'($urandom_range(0, GSK_COUNTED_MIN - 1)));
            repeat ($urandom_range(5)) send_byte(8'($urandom_range(1, 255)));
            send_byte(CH_NUL);
        end else if (pick < 70) begin
            send_byte(CH_GS);
            send_byte(GS_BLOCK);
            send_random_bytes(1);
            n = $urandom_range(6);
            send_byte(8'(n));
            send_byte(8'h00);
            send_random_bytes(n);
        end else if (pick < 76) begin
            if ($urandom_range(1)) begin
                send_byte(CH_FS);
                send_random_bytes(2);
            end else begin
                send_byte(CH_DLE);
                send_random_bytes(3);
            end
        end else if (pick < 80) begin
            send_byte(CH_GS);
            send_random_bytes(2);
        end else if (pick < 88) begin
            send_random_bytes($urandom_range(1, 3));
        end else if (pick < 94) begin
            send_item(8'($urandom_range(255)), 1'b1);
        end else begin
            // Cut a command short with the receipt end.
            case ($urandom_range(2))
                0: begin
                    send_byte(CH_GS);
                    send_byte(GS_BLOCK);
                    send_random_bytes(2);
                    send_byte(8'($urandom_range(1, 255)));
                end
                1: begin
                    send_byte(CH_GS);
                    send_byte(GS_BARCODE);
                    send_byte(8'($urandom_range(0, GSK_COUNTED_MIN - 1)));
                end
                default: send_byte($urandom_range(1) ? CH_ESC : CH_DLE);
            endcase
            send_item(8'($urandom_range(1, 255)), 1'b1);
        end
    endtask

    initial begin
        int target;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        run_space_saturation();
        run_buffer_full();

        for (int p = 0; p < PHASES; p++) begin
            tx_idle_pct  = phase_tx_pct[p];
            rx_stall_pct <= phase_rx_pct[p];
            target = items_sent + RANDOM_PER_PHASE;
            while (items_sent < target)
                send_random_chunk();
        end
        send_item(CH_SPACE, 1'b1);

        // Drain: wait out every pending result, then the pipeline depth.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && results_owed == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== escpos_text_extractor_top.f =====
rtl/core/ete_pkg.sv
rtl/core/ete_parser.sv
rtl/core/ete_serializer.sv
rtl/core/escpos_text_extractor_top.sv
bench/escpos_checker.sv
bench/tb.sv
